/* sv/les_pkg.sv */
// Shared constants and types of the Laplacian edge filter.
`timescale 1ns / 1ps
package les_pkg;

  localparam int DefMaxWidth   = 1024;
  localparam int DefPixelBits  = 8;
  localparam int CfgWidthBits  = 11;
  localparam int EdgeBits      = 11;
  localparam int ResetWidth    = 640;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Control information that travels with an item from the column logic to the kernel.
  typedef struct packed {
    logic emit;      // item gives a result
    logic last;      // item is in the last column of its row
    logic flush;     // item stands for the zero row below the image
    logic up_zero;   // results are for the top image row
    logic col_zero;  // item is in column zero
    logic sel;       // which line store holds the previous row
  } les_tag_t;

endpackage

/* sv/les_line_store.sv */
// One line store: a synchronous memory with one write port and one registered read port.
`timescale 1ns / 1ps
module les_line_store #(
  parameter int Depth     = 1024,
  parameter int DataBits  = 8
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(Depth)-1:0]    waddr_i,
  input  logic [DataBits-1:0]         wdata_i,
  input  logic                        re_i,
  input  logic [$clog2(Depth)-1:0]    raddr_i,
  output logic [DataBits-1:0]         rdata_o
);

  logic [DataBits-1:0] mem [Depth];
  logic [DataBits-1:0] rdata_q;

  // The read sees the entry as it was before a write at the same edge.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/les_kernel.sv */
// Neighbour window, Laplacian arithmetic and output register of the edge filter.
`timescale 1ns / 1ps
module les_kernel
  import les_pkg::*;
#(
  parameter int PixelBits = DefPixelBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  les_tag_t                   tag_i,
  input  logic [PixelBits-1:0]       pix_i,
  input  logic [PixelBits-1:0]       first_pix_i,
  input  logic [PixelBits-1:0]       rd_a_i,
  input  logic [PixelBits-1:0]       rd_b_i,
  output logic                       hold_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [EdgeBits-1:0] edge_value_o,
  output logic                       row_end_o,
  output logic                       frame_end_o
);

  localparam int SumBits = (PixelBits + 4 > EdgeBits) ? PixelBits + 4 : EdgeBits;

  logic                 s1_valid_q, s1_valid_d;
  les_tag_t             s1_tag_q;
  logic [PixelBits-1:0] s1_pix_q;
  logic [PixelBits-1:0] s1_first_q;
  logic [PixelBits-1:0] win_left_q, win_centre_q;
  logic                 s1_adv;
  logic                 out_free;

  logic [PixelBits-1:0] rd_mid, rd_old;
  logic [PixelBits-1:0] up, left, centre, right;
  logic [SumBits-1:0]   sum;

  logic                 out_valid_q, out_valid_d;
  logic [EdgeBits-1:0]  edge_q;
  logic                 row_end_q, frame_end_q;

  assign out_free = !out_valid_q || !out_stall_i;
  // Items that give no result pass through without waiting for the output register.
  assign s1_adv   = s1_valid_q && (!s1_tag_q.emit || out_free);
  assign hold_o   = s1_valid_q && !s1_adv;

  assign rd_mid = s1_tag_q.sel ? rd_a_i : rd_b_i;
  assign rd_old = s1_tag_q.sel ? rd_b_i : rd_a_i;

  always_comb begin
    up     = s1_tag_q.up_zero  ? '0 : rd_old;
    left   = s1_tag_q.col_zero ? '0 : win_left_q;
    centre = s1_tag_q.col_zero ? s1_first_q : win_centre_q;
    right  = s1_tag_q.last     ? '0 : rd_mid;
    sum    = SumBits'(up) + SumBits'(s1_pix_q) + SumBits'(left) + SumBits'(right)
           - (SumBits'(centre) << 2);
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && s1_tag_q.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_tag_q   <= tag_i;
      s1_pix_q   <= pix_i;
      s1_first_q <= first_pix_i;
    end
    // The window slides by one column for every item that leaves the stage.
    if (s1_adv) begin
      win_left_q   <= centre;
      win_centre_q <= rd_mid;
    end
    if (s1_adv && s1_tag_q.emit) begin
      edge_q      <= sum[EdgeBits-1:0];
      row_end_q   <= s1_tag_q.last;
      frame_end_q <= s1_tag_q.last && s1_tag_q.flush;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_value_o = $signed(edge_q);
  assign row_end_o    = row_end_q;
  assign frame_end_o  = frame_end_q;

  a_accept_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |-> !hold_o)
    else $error("item taken while the window stage was held");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_tag_q.emit))
    else $error("result appeared without an item that gives one");

  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_end_q |-> row_end_q)
    else $error("frame end without row end");

endmodule

/* sv/laplacian_edge_filter_unit.sv */
// Top level of the streaming 4-neighbour Laplacian edge filter.
// Pixels arrive in raster order and each one below the first row gives the Laplacian of the
// pixel one row above it, so a row's results come out while the next row streams in; a row
// of flush items (kind = 1) after the image pushes out the last row. The filter takes
// one item per clock unless a result waits on a stalled output, limited by the single read
// port of each line store. Two line stores of MAX_WIDTH entries hold the previous row and
// the row before it; neither needs clearing after reset. The user is to write the image
// width over the configuration channel while the filter is idle; the block does not enforce
// it. Zero acts as one and values above MAX_WIDTH act as MAX_WIDTH.
`timescale 1ns / 1ps
module laplacian_edge_filter_unit
  import les_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int PIXEL_BITS = DefPixelBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgWidthBits-1:0]    image_width_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [PIXEL_BITS-1:0]      pixel_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [EdgeBits-1:0] edge_value_o,
  output logic                       row_end_o,
  output logic                       frame_end_o
);

  localparam int ColBits = $clog2(MAX_WIDTH);
  localparam int ResetLast = ((ResetWidth < MAX_WIDTH) ? ResetWidth : MAX_WIDTH) - 1;

  logic [ColBits-1:0]    col_q, col_d;
  logic [ColBits-1:0]    last_col_q, last_col_d;
  logic                  first_q, first_d;
  logic                  second_q, second_d;
  logic                  sel_q, sel_d;
  logic [PIXEL_BITS-1:0] cur_first_q, mid_first_q, mid_first_d;

  logic                  acc;
  logic                  flush;
  logic                  last;
  logic [PIXEL_BITS-1:0] pix;
  logic [ColBits-1:0]    col_next;
  logic [31:0]           cfg_value;
  les_tag_t              tag;
  logic                  hold;
  logic [PIXEL_BITS-1:0] rd_a, rd_b;

  assign in_stall_o  = hold;
  assign acc         = in_valid_i && !hold;
  assign cfg_ready_o = 1'b1;

  assign flush    = (kind_i == KIND_FLUSH);
  assign pix      = flush ? '0 : pixel_i;
  assign last     = (col_q >= last_col_q);
  assign col_next = ColBits'(col_q + 1'b1);

  always_comb begin
    tag.emit     = !first_q;
    tag.last     = last;
    tag.flush    = flush;
    tag.up_zero  = second_q;
    tag.col_zero = (col_q == '0);
    tag.sel      = sel_q;
  end

  always_comb begin
    cfg_value  = 32'(image_width_i);
    last_col_d = last_col_q;
    if (cfg_valid_i) begin
      if (cfg_value == 32'd0) begin
        last_col_d = '0;
      end else if (cfg_value > 32'(MAX_WIDTH)) begin
        last_col_d = ColBits'(MAX_WIDTH - 1);
      end else begin
        last_col_d = ColBits'(cfg_value - 32'd1);
      end
    end
  end

  always_comb begin
    col_d       = col_q;
    first_d     = first_q;
    second_d    = second_q;
    sel_d       = sel_q;
    mid_first_d = mid_first_q;
    if (acc) begin
      if (last) begin
        col_d = '0;
        if (flush) begin
          first_d  = 1'b1;
          second_d = 1'b0;
        end else begin
          second_d = first_q;
          first_d  = 1'b0;
          sel_d    = !sel_q;
          // In a one-column row the first pixel is this very item.
          mid_first_d = tag.col_zero ? pix : cur_first_q;
        end
      end else begin
        col_d = col_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      last_col_q <= ColBits'(ResetLast);
      first_q    <= 1'b1;
      second_q   <= 1'b0;
      sel_q      <= 1'b0;
    end else begin
      col_q      <= col_d;
      last_col_q <= last_col_d;
      first_q    <= first_d;
      second_q   <= second_d;
      sel_q      <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && tag.col_zero) begin
      cur_first_q <= pix;
    end
    mid_first_q <= mid_first_d;
  end

  // The store that holds the previous row is read one column ahead; the other one gives the
  // pixel above and then takes the new pixel at the same entry.
  les_line_store #(
    .Depth    (MAX_WIDTH),
    .DataBits (PIXEL_BITS)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (acc && !sel_q),
    .waddr_i (col_q),
    .wdata_i (pix),
    .re_i    (acc),
    .raddr_i (sel_q ? col_next : col_q),
    .rdata_o (rd_a)
  );

  les_line_store #(
    .Depth    (MAX_WIDTH),
    .DataBits (PIXEL_BITS)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (acc && sel_q),
    .waddr_i (col_q),
    .wdata_i (pix),
    .re_i    (acc),
    .raddr_i (sel_q ? col_q : col_next),
    .rdata_o (rd_b)
  );

  les_kernel #(
    .PixelBits (PIXEL_BITS)
  ) u_kernel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .tag_i        (tag),
    .pix_i        (pix),
    .first_pix_i  (mid_first_q),
    .rd_a_i       (rd_a),
    .rd_b_i       (rd_b),
    .hold_o       (hold),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .edge_value_o (edge_value_o),
    .row_end_o    (row_end_o),
    .frame_end_o  (frame_end_o)
  );

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(first_q && second_q))
    else $error("first and second row pending together");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last && flush |=> first_q && (col_q == '0))
    else $error("frame end did not return to the first row");

endmodule

/* verif/laplacian_edge_filter_unit_tb.sv */
// Self-checking testbench for the streaming Laplacian edge filter with a built-in predictor.
`timescale 1ns / 1ps
module laplacian_edge_filter_unit_tb;
  import les_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int SettleDelay = 8;     // result path has a window stage and an output register; allow margin
  localparam int IdleLimit   = 4000;
  localparam int RandomItems = 680;

  typedef struct packed {
    logic signed [EdgeBits-1:0] edge_value;
    logic                       row_end;
    logic                       frame_end;
  } edge_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CfgWidthBits-1:0]    cfg_width;
  logic                       in_valid;
  logic                       in_stall;
  logic                       kind;
  logic [DefPixelBits-1:0]    pixel;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [EdgeBits-1:0] edge_value;
  logic                       row_end;
  logic                       frame_end;

  // Predictor state: index 0 is the upper row store and index 1 the middle one until rows_swapped flips them.
  logic [DefPixelBits-1:0] line_rows [2][DefMaxWidth];
  logic [CfgWidthBits-1:0] width_cfg = CfgWidthBits'(ResetWidth);
  int unsigned             col_pos = 0;
  bit                      top_row_pending = 1'b1;
  bit                      second_row_pending = 1'b0;
  bit                      rows_swapped = 1'b0;

  edge_result_t pending_edges[$];
  int           error_count = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  bit           gaps_on = 1'b1;
  int           stall_tick = 0;
  int           stall_mode = 0;

  laplacian_edge_filter_unit uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .image_width_i(cfg_width),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .pixel_i      (pixel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .edge_value_o (edge_value),
    .row_end_o    (row_end),
    .frame_end_o  (frame_end)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  function automatic void predict_laplacian(input logic k, input logic [DefPixelBits-1:0] p);
    int unsigned  w;
    int unsigned  c;
    int           up;
    int           left;
    int           right;
    int           centre;
    int           lap;
    int           mid_idx;
    int           old_idx;
    bit           last;
    bit           is_flush;
    logic [DefPixelBits-1:0] v;
    edge_result_t res;
    w = 32'(width_cfg);
    if (w == 0) w = 1;
    if (w > DefMaxWidth) w = DefMaxWidth;
    is_flush = (k == KIND_FLUSH);
    v = is_flush ? '0 : p;
    mid_idx = rows_swapped ? 0 : 1;
    old_idx = rows_swapped ? 1 : 0;
    c = col_pos;
    if (c >= DefMaxWidth) c = DefMaxWidth - 1;
    last = (c >= w - 1);
    if (!top_row_pending) begin
      up = second_row_pending ? 0 : int'(line_rows[old_idx][c]);
      left = (c != 0) ? int'(line_rows[mid_idx][c-1]) : 0;
      right = (!last && c + 1 < DefMaxWidth) ? int'(line_rows[mid_idx][c+1]) : 0;
      centre = int'(line_rows[mid_idx][c]);
      lap = up + int'(v) + left + right - 4 * centre;
      res.edge_value = lap[EdgeBits-1:0];
      res.row_end = last;
      res.frame_end = last && is_flush;
      pending_edges.push_back(res);
    end
    line_rows[old_idx][c] = v;
    if (last) begin
      col_pos = 0;
      if (is_flush) begin
        top_row_pending = 1'b1;
        second_row_pending = 1'b0;
      end else begin
        second_row_pending = top_row_pending;
        top_row_pending = 1'b0;
        rows_swapped = !rows_swapped;
      end
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void compare_edge_result();
    edge_result_t want;
    if (pending_edges.size() == 0) begin
      $display("%0t: unexpected result, edge_value %0d row_end %0b frame_end %0b",
               $time, edge_value, row_end, frame_end);
      error_count++;
    end else begin
      want = pending_edges.pop_front();
      if (edge_value !== want.edge_value) begin
        $display("%0t: edge_value expected %0d actual %0d", $time, want.edge_value, edge_value);
        error_count++;
      end
      if (row_end !== want.row_end) begin
        $display("%0t: row_end expected %0b actual %0b", $time, want.row_end, row_end);
        error_count++;
      end
      if (frame_end !== want.frame_end) begin
        $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end, frame_end);
        error_count++;
      end
    end
  endfunction

  // Input transfers are predicted before output transfers are checked at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) width_cfg = cfg_width;
      if (in_valid && !in_stall) predict_laplacian(kind, pixel);
      if (out_valid && !out_stall) compare_edge_result();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // The receiver switches between free running, random, periodic and long stalls.
  always @(negedge clk) begin
    if (stall_tick % 200 == 0) stall_mode = $urandom_range(0, 3);
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((stall_tick % 5) >= 3);
      default: out_stall <= ((stall_tick % 32) < 12);
    endcase
  end

  function automatic logic [DefPixelBits-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return DefPixelBits'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input logic k, input logic [DefPixelBits-1:0] p);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    pixel <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (SettleDelay) @(negedge clk);
  endtask

  task automatic write_width(input logic [CfgWidthBits-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_width <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // An optional flush row, pixel rows with the odd flush item, then a mostly flush row that ends the frame.
  task automatic send_frame(input int unsigned w, input int unsigned rows, input bit lead_flush);
    if (lead_flush) begin
      repeat (w) send_item(KIND_FLUSH, rand_pixel());
    end
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        if (c != w - 1 && $urandom_range(0, 15) == 0) send_item(KIND_FLUSH, rand_pixel());
        else if (c == w - 1 && $urandom_range(0, 19) == 0) send_item(KIND_FLUSH, rand_pixel());
        else send_item(KIND_PIXEL, rand_pixel());
      end
    end
    for (int unsigned c = 0; c < w; c++) begin
      if (c != w - 1 && $urandom_range(0, 7) == 0) send_item(KIND_PIXEL, rand_pixel());
      else send_item(KIND_FLUSH, rand_pixel());
    end
  endtask

  // A bright cross and a dark centre give the largest and smallest edge values.
  task automatic test_edge_extremes();
    logic [DefPixelBits-1:0] img [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                         8'd0, 8'd255, 8'd0};
    write_width(CfgWidthBits'(3));
    foreach (img[i]) send_item(KIND_PIXEL, img[i]);
    repeat (3) send_item(KIND_FLUSH, rand_pixel());
    drain_results();
  endtask

  // A width of zero behaves as a single column.
  task automatic test_single_column();
    write_width(CfgWidthBits'(0));
    send_item(KIND_PIXEL, 8'hC5);
    send_item(KIND_PIXEL, 8'h3A);
    send_item(KIND_FLUSH, 8'hFF);
    drain_results();
  endtask

  // A flush ahead of the image, then a row that mixes flush and pixel items.
  task automatic test_flush_first();
    write_width(CfgWidthBits'(2));
    send_item(KIND_FLUSH, 8'h00);
    send_item(KIND_FLUSH, 8'hAA);
    send_item(KIND_PIXEL, 8'd10);
    send_item(KIND_PIXEL, 8'd20);
    send_item(KIND_FLUSH, 8'h55);
    send_item(KIND_PIXEL, 8'd77);
    send_item(KIND_FLUSH, 8'h0F);
    send_item(KIND_FLUSH, 8'hF0);
    drain_results();
  endtask

  // Narrowing the width past the current column ends the row at the next item.
  task automatic test_width_cut_mid_row();
    write_width(CfgWidthBits'(1024));
    send_item(KIND_PIXEL, 8'd255);
    send_item(KIND_PIXEL, 8'd1);
    send_item(KIND_PIXEL, 8'd128);
    drain_results();
    write_width(CfgWidthBits'(2));
    send_item(KIND_PIXEL, 8'd254);
    send_item(KIND_PIXEL, 8'h0F);
    send_item(KIND_PIXEL, 8'hF0);
    send_item(KIND_FLUSH, 8'h81);
    send_item(KIND_FLUSH, 8'h7E);
    drain_results();
  endtask

  // Widths above the line store size act as the full store size, so a full-store row ends at
  // its last entry and a narrow row after it sees the stored pixels.
  task automatic test_wide_rows();
    write_width(CfgWidthBits'(2047));
    gaps_on = 1'b1;
    for (int unsigned c = 0; c < DefMaxWidth; c++) send_item(KIND_PIXEL, rand_pixel());
    drain_results();
    write_width(CfgWidthBits'(2));
    repeat (2) send_item(KIND_PIXEL, rand_pixel());
    repeat (2) send_item(KIND_FLUSH, rand_pixel());
    drain_results();
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned w_cfg;
    int unsigned w_eff;
    int unsigned rows;
    bit          lead;
    sent = 0;
    w_eff = 1;
    while (sent < RandomItems) begin
      // The width only changes once every result is out; this is also the sender's pause.
      if (sent == 0 || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: w_cfg = 0;
          1: w_cfg = 1;
          2, 3, 4, 5: w_cfg = $urandom_range(2, 8);
          default: w_cfg = $urandom_range(9, 40);
        endcase
        drain_results();
        write_width(CfgWidthBits'(w_cfg));
        w_eff = (w_cfg == 0) ? 1 : w_cfg;
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      rows = $urandom_range(1, 5);
      lead = ($urandom_range(0, 7) == 0);
      send_frame(w_eff, rows, lead);
      sent += (rows + 1 + lead) * w_eff;
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_width = '0;
    in_valid = 1'b0;
    kind = KIND_PIXEL;
    pixel = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_edge_extremes();
    test_single_column();
    test_flush_first();
    test_width_cut_mid_row();
    test_wide_rows();
    test_random_frames();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/les_pkg.sv
sv/les_line_store.sv
sv/les_kernel.sv
sv/laplacian_edge_filter_unit.sv
verif/laplacian_edge_filter_unit_tb.sv
